@@ sv/lmb_pkg.sv @@
// Shared types, constants and helpers for the LED level meter ballistics block.
package lmb_pkg;

	// Field widths
	localparam int CH_W   = 4;
	localparam int DB_W   = 16;
	localparam int GAIN_W = 16;

	// Channel count: default and the most the channel field can address
	localparam int CHANNELS_DEF = 16;
	localparam int CH_COUNT     = 1 << CH_W;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = 34;

	// Level thresholds in signed Q8.8 dB
	localparam logic signed [DB_W-1:0] FLOOR_DB  = -16'sd25600;
	localparam logic signed [DB_W-1:0] CEIL_DB   = 16'sd1536;
	localparam logic signed [DB_W-1:0] OFF_DB    = -16'sd15360;
	localparam logic signed [DB_W-1:0] GREEN_DB  = -16'sd2048;
	localparam logic signed [DB_W-1:0] YELLOW_DB = -16'sd256;

	// Register map and reset values
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE = 1'b1;
	localparam logic [GAIN_W-1:0] ATTACK_RST  = 16'd40632;
	localparam logic [GAIN_W-1:0] RELEASE_RST = 16'd7209;

	// Colour classes
	localparam logic [1:0] COLOUR_GREEN  = 2'd0;
	localparam logic [1:0] COLOUR_YELLOW = 2'd1;
	localparam logic [1:0] COLOUR_RED    = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0]        channel;
		logic signed [DB_W-1:0] level_db;
	} lmb_in_t;

	typedef struct packed {
		logic [CH_W-1:0]        out_channel;
		logic signed [DB_W-1:0] smoothed_db;
		logic                   lit;
		logic [1:0]             colour_class;
		logic [7:0]             brightness;
	} lmb_out_t;

	// Write request into the level store
	typedef struct packed {
		logic                   en;
		logic [CH_W-1:0]        addr;
		logic signed [DB_W-1:0] level;
	} lmb_wr_t;

	// Clamp an 18-bit signed level into -100..+6 dB
	function automatic logic signed [DB_W-1:0] clamp_db(input logic signed [DB_W+1:0] v);
		logic signed [DB_W-1:0] r;
		if (v < (DB_W+2)'(FLOOR_DB)) begin
			r = FLOOR_DB;
		end else if (v > (DB_W+2)'(CEIL_DB)) begin
			r = CEIL_DB;
		end else begin
			r = v[DB_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/lmb_mul.sv @@
// Shared signed-by-unsigned multiplier with a registered product.
module lmb_mul #(
	parameter int A_W = lmb_pkg::MUL_A_W,
	parameter int B_W = lmb_pkg::MUL_B_W
) (
	input  logic                   clk,
	input  logic signed [A_W-1:0]  a,
	input  logic        [B_W-1:0]  b,
	output logic signed [A_W+B_W-1:0] p
);

	logic signed [A_W+B_W:0] full;

	// Form the full product; b is treated as unsigned
	assign full = a * $signed({1'b0, b});

	// Register the product for the next step of the sequencer
	always_ff @(posedge clk) begin
		p <= full[A_W+B_W-1:0];
	end

endmodule

@@ sv/lmb_store.sv @@
// Per-channel smoothed level memory with reset-cleared valid bits.
module lmb_store #(
	parameter int DEPTH = lmb_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [lmb_pkg::CH_W-1:0]            rd_addr,
	output logic signed [lmb_pkg::DB_W-1:0]     rd_level,
	input  lmb_pkg::lmb_wr_t                    wr
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [lmb_pkg::DB_W-1:0] mem [DEPTH];
	logic signed [lmb_pkg::DB_W-1:0] rd_data_q;
	logic [DEPTH-1:0]                vld_q;
	logic                            rd_vld_q;

	// Write and read the level array
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.level;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[AW-1:0]];
		end
	end

	// Track which entries hold a written level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr[AW-1:0]];
			end
		end
	end

	// Return the floor level for entries not yet written
	assign rd_level = rd_vld_q ? rd_data_q : lmb_pkg::FLOOR_DB;

endmodule

@@ sv/led_level_meter_ballistics.sv @@
// Top level: attack/release level meter with per-channel smoothing and LED mapping.
//
//   port group   direction  handshake           contents
//   cfg_*        in         cfg_we              attack_gain / release_gain writes
//   in_*         in         in_valid/in_stall   channel, level_db
//   out_*        out        out_valid/out_stall out_channel, smoothed_db, lit,
//                                               colour_class, brightness
//
// A request passes through S_DIFF, S_UPD, S_SCALE, S_NORM, S_RECIP and S_OUT to the
// output register (S_RECIP is skipped from -8 to -1 dB, S_NORM and S_RECIP below
// -60 dB or for a channel past the store), and S_OUT waits while out_stall holds the
// last result; the next request is taken the cycle after. The shared multiplier is used up to three times per request.
// in_stall is high from the cycle after acceptance until the result is loaded.
// Reset clears all channel levels to -100 dB at once; no clearing pass.
module led_level_meter_ballistics #(
	parameter int CHANNELS = lmb_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lmb_pkg::REG_IDX_W-1:0]     cfg_idx,
	input  logic [lmb_pkg::GAIN_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  lmb_pkg::lmb_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lmb_pkg::lmb_out_t                 out_data
);

	localparam int DEPTH = (CHANNELS < lmb_pkg::CH_COUNT) ? CHANNELS : lmb_pkg::CH_COUNT;
	localparam int DB_W  = lmb_pkg::DB_W;
	localparam int X_W   = 14;
	localparam int N_W   = 23;
	localparam int M_W   = 12;

	// Brightness segments: b = (offset + coef * x) / den, den split as shift and divisor
	localparam logic [lmb_pkg::MUL_B_W-1:0] COEF_LOW  = 16'd357;
	localparam logic [lmb_pkg::MUL_B_W-1:0] COEF_MID  = 16'd51;
	localparam logic [lmb_pkg::MUL_B_W-1:0] COEF_TOP  = 16'd153;
	localparam logic [N_W-1:0]              OFFS_LOW  = 23'd1031680;
	localparam logic [N_W-1:0]              OFFS_MID  = 23'd157184;
	localparam logic [N_W-1:0]              OFFS_TOP  = 23'd287872;
	// Reciprocals of 13 and 5 in Q0.16, exact for the quotients in range
	localparam logic [lmb_pkg::MUL_B_W-1:0] RECIP_13  = 16'd5042;
	localparam logic [lmb_pkg::MUL_B_W-1:0] RECIP_5   = 16'd13108;
	localparam logic [8:0]                  BRIGHT_HI = 9'd255;
	localparam logic [8:0]                  BRIGHT_LO = 9'd191;

	typedef enum logic [2:0] {
		S_IDLE, S_DIFF, S_UPD, S_SCALE, S_NORM, S_RECIP, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEG_OFF, SEG_LOW, SEG_MID, SEG_TOP
	} seg_t;

	state_t                           state_q;
	seg_t                             seg_q;
	seg_t                             seg_d;
	logic [lmb_pkg::CH_W-1:0]         ch_q;
	logic                             bad_q;
	logic signed [DB_W-1:0]           target_q;
	logic signed [DB_W-1:0]           next_q;
	logic [7:0]                       bright_q;
	logic [lmb_pkg::GAIN_W-1:0]       attack_q;
	logic [lmb_pkg::GAIN_W-1:0]       release_q;
	logic                             out_valid_q;
	lmb_pkg::lmb_out_t                out_q;

	logic                             accept;
	logic                             in_range;
	logic                             out_free;
	logic signed [DB_W-1:0]           cur_level;
	logic signed [DB_W:0]             diff;
	logic signed [DB_W-1:0]           xdiff;
	logic [X_W-1:0]                   x_d;
	logic [lmb_pkg::MUL_B_W-1:0]      coef_d;
	logic [N_W-1:0]                   n_d;
	logic [M_W-1:0]                   m_d;
	logic signed [lmb_pkg::MUL_P_W-1:0] rnd_sum;
	logic signed [DB_W+1:0]           upd_sum;
	logic signed [DB_W-1:0]           upd_level;
	logic [8:0]                       quot;
	logic [1:0]                       colour_d;
	logic signed [lmb_pkg::MUL_A_W-1:0] mul_a;
	logic [lmb_pkg::MUL_B_W-1:0]      mul_b;
	logic signed [lmb_pkg::MUL_P_W-1:0] prod;
	lmb_pkg::lmb_wr_t                 wr;

	// Input handshake
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = ({1'b0, in_data.channel} < (lmb_pkg::CH_W+1)'(DEPTH));
	assign out_free = !out_valid_q || !out_stall;

	lmb_store #(.DEPTH(DEPTH)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && in_range),
		.rd_addr  (in_data.channel),
		.rd_level (cur_level),
		.wr       (wr)
	);

	lmb_mul #(.A_W(lmb_pkg::MUL_A_W), .B_W(lmb_pkg::MUL_B_W)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Step toward the target: difference, then rounded product added back
	assign diff      = {target_q[DB_W-1], target_q} - {cur_level[DB_W-1], cur_level};
	assign rnd_sum   = prod + lmb_pkg::MUL_P_W'(32768);
	assign upd_sum   = {{2{cur_level[DB_W-1]}}, cur_level} + rnd_sum[lmb_pkg::MUL_P_W-1:16];
	assign upd_level = lmb_pkg::clamp_db(upd_sum);

	// Store the new level for in-range channels
	always_comb begin
		wr.en    = (state_q == S_UPD) && !bad_q;
		wr.addr  = ch_q;
		wr.level = upd_level;
	end

	// Pick the brightness segment and its offset within it
	always_comb begin
		priority if (next_q < lmb_pkg::OFF_DB) begin
			seg_d = SEG_OFF;
		end else if (next_q < lmb_pkg::GREEN_DB) begin
			seg_d = SEG_LOW;
		end else if (next_q < lmb_pkg::YELLOW_DB) begin
			seg_d = SEG_MID;
		end else begin
			seg_d = SEG_TOP;
		end
		unique case (seg_d)
			SEG_LOW: begin
				xdiff  = next_q - lmb_pkg::OFF_DB;
				coef_d = COEF_LOW;
			end
			SEG_MID: begin
				xdiff  = next_q - lmb_pkg::GREEN_DB;
				coef_d = COEF_MID;
			end
			SEG_TOP: begin
				xdiff  = next_q - lmb_pkg::YELLOW_DB;
				coef_d = COEF_TOP;
			end
			default: begin
				xdiff  = '0;
				coef_d = '0;
			end
		endcase
		x_d = xdiff[X_W-1:0];
	end

	// Add the segment offset and drop the power-of-two part of the divisor
	always_comb begin
		unique case (seg_q)
			SEG_LOW: n_d = prod[N_W-1:0] + OFFS_LOW;
			SEG_MID: n_d = prod[N_W-1:0] + OFFS_MID;
			SEG_TOP: n_d = prod[N_W-1:0] + OFFS_TOP;
			default: n_d = '0;
		endcase
		unique case (seg_q)
			SEG_LOW: m_d = n_d[22:11];
			SEG_TOP: m_d = n_d[19:8];
			default: m_d = '0;
		endcase
	end

	// Route operands into the shared multiplier
	always_comb begin
		unique case (state_q)
			S_DIFF: begin
				mul_a = {diff[DB_W], diff};
				mul_b = (!diff[DB_W] && (diff != '0)) ? attack_q : release_q;
			end
			S_SCALE: begin
				mul_a = {{(lmb_pkg::MUL_A_W-X_W){1'b0}}, x_d};
				mul_b = coef_d;
			end
			S_NORM: begin
				mul_a = {{(lmb_pkg::MUL_A_W-M_W){1'b0}}, m_d};
				mul_b = (seg_q == SEG_LOW) ? RECIP_13 : RECIP_5;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Colour class of the new level
	assign quot = prod[24:16];
	always_comb begin
		priority if (next_q >= lmb_pkg::YELLOW_DB) begin
			colour_d = lmb_pkg::COLOUR_RED;
		end else if (next_q >= lmb_pkg::GREEN_DB) begin
			colour_d = lmb_pkg::COLOUR_YELLOW;
		end else begin
			colour_d = lmb_pkg::COLOUR_GREEN;
		end
	end

	// Sequencer, configuration registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			attack_q    <= lmb_pkg::ATTACK_RST;
			release_q   <= lmb_pkg::RELEASE_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					lmb_pkg::REG_ATTACK:  attack_q  <= cfg_wdata;
					lmb_pkg::REG_RELEASE: release_q <= cfg_wdata;
				endcase
			end

			// Raise valid on a loaded result, drop it once taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q     <= in_data.channel;
						bad_q    <= !in_range;
						target_q <= lmb_pkg::clamp_db({{2{in_data.level_db[DB_W-1]}},
							in_data.level_db});
						state_q  <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					next_q  <= bad_q ? lmb_pkg::FLOOR_DB : upd_level;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					seg_q <= seg_d;
					if (seg_d == SEG_OFF) begin
						bright_q <= '0;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (seg_q == SEG_MID) begin
						bright_q <= n_d[17:10];
						state_q  <= S_OUT;
					end else begin
						state_q <= S_RECIP;
					end
				end
				S_RECIP: begin
					// Clip the top segment to 0.75..1
					if (seg_q == SEG_TOP && quot > BRIGHT_HI) begin
						bright_q <= BRIGHT_HI[7:0];
					end else if (seg_q == SEG_TOP && quot < BRIGHT_LO) begin
						bright_q <= BRIGHT_LO[7:0];
					end else begin
						bright_q <= quot[7:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q.out_channel  <= ch_q;
						out_q.smoothed_db  <= next_q;
						out_q.lit          <= (next_q >= lmb_pkg::OFF_DB);
						out_q.colour_class <= colour_d;
						out_q.brightness   <= bright_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/lmb_chk.sv @@
// Port-level checks for the level meter, bound to the top level.
module lmb_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input lmb_pkg::lmb_out_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Block further requests while one is in progress
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// Lit flag follows the level, and an unlit meter is dark
	a_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.lit == (out_data.smoothed_db >= lmb_pkg::OFF_DB))
			&& (out_data.lit || out_data.brightness == 8'd0))
		else $error("lit flag or dark brightness inconsistent");

	// Red segment is lit and at least three quarters bright
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.colour_class == lmb_pkg::COLOUR_RED
			|-> out_data.lit && out_data.brightness >= 8'd191)
		else $error("red class with low brightness");

	// Smoothed level stays within -100..+6 dB
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.smoothed_db >= lmb_pkg::FLOOR_DB
			&& out_data.smoothed_db <= lmb_pkg::CEIL_DB)
		else $error("smoothed level out of range");

endmodule

bind led_level_meter_ballistics lmb_chk u_lmb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
